// ===== hdl/bra_pkg.sv =====
package bra_pkg;

    localparam int MAP_BITS  = 1024;
    localparam int WORD_BITS = 32;
    localparam int MAP_WORDS = MAP_BITS / WORD_BITS;
    localparam int WADDR_W   = $clog2(MAP_WORDS);
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int IDX_W     = $clog2(MAP_BITS);
    localparam int CNT_W     = 11;
    localparam int POS_W     = 32;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [1:0] {
        CMD_SET  = 2'd0,
        CMD_CLR  = 2'd1,
        CMD_FIND = 2'd2,
        CMD_NOP  = 2'd3
    } t_cmd;

    typedef logic [WORD_BITS-1:0] t_word;

    typedef struct packed {
        logic               rd_en;
        logic [WADDR_W-1:0] rd_addr;
        logic               wr_en;
        logic [WADDR_W-1:0] wr_addr;
        t_word              wr_data;
    } t_mem_req;

    typedef struct packed {
        logic [POS_W-1:0] base;
        logic [CNT_W-1:0] cnt;
        logic [POS_W-1:0] first;
        logic [CNT_W-1:0] want;
    } t_scan_ctx;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] pos;
        logic [CNT_W-1:0] cnt;
        logic [POS_W-1:0] first;
    } t_scan_res;

endpackage

// ===== hdl/bitmap_run_allocator.sv =====
// bitmap run allocator: a 1024-bit map of used marks, one bit per unit
// input channel (i_in_valid / o_in_stall) carries one command per transaction:
//   set marks a bit range used, clear marks it free, find scans from the start
//   index up to scan_end for a run of run_length free bits, with the running
//   count and run start carried in and out so a search can continue across chunks
// output channel (o_out_valid / i_out_stall) returns exactly one result per
//   transaction; set, clear and the unused code give an all-zero result
// the map sits in a 32 x 32 synchronous ram; one word is read and, for set and
//   clear, written back each cycle while a command runs, from the start word
//   up to the last word of the range; empty ranges, empty scans and the unused
//   code touch no word and go straight to their result
// a find stops at the first word holding a match
// one command is in flight at a time; o_in_stall is high from acceptance until
//   the result is moved to the output register
// the output register holds a result while i_out_stall is high; the next
//   command is accepted meanwhile and waits before its own result if needed
// reset (synchronous, active low) marks every bit free at once and empties
//   the output register; no clearing pass is needed
module bitmap_run_allocator import bra_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [1:0]       i_cmd,
    input  logic [IDX_W-1:0] i_start_idx,
    input  logic [CNT_W-1:0] i_bit_count,
    input  logic [CNT_W-1:0] i_scan_end,
    input  logic [CNT_W-1:0] i_run_length,
    input  logic [POS_W-1:0] i_base_offset,
    input  logic [CNT_W-1:0] i_carry_count_in,
    input  logic [POS_W-1:0] i_carry_first_in,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic             o_found,
    output logic [POS_W-1:0] o_found_position,
    output logic [CNT_W-1:0] o_carry_count_out,
    output logic [POS_W-1:0] o_carry_first_out
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state             r_state;
    logic [1:0]         r_cmd;
    logic [WADDR_W-1:0] r_lo_w;
    logic [WADDR_W-1:0] r_hi_w;
    logic [BIT_W-1:0]   r_lo_b;
    logic [BIT_W-1:0]   r_hi_b;
    t_scan_ctx          r_ctx;
    logic [WADDR_W-1:0] r_rd_w;
    logic               r_rd_more;
    logic               r_dv;
    logic [WADDR_W-1:0] r_proc_w;
    t_scan_res          r_res;
    logic               r_o_valid;
    t_scan_res          r_o_res;

    logic               accept;
    logic [CNT_W:0]     range_end;
    logic [CNT_W:0]     cand_end;
    logic [CNT_W-1:0]   end_c;
    logic [CNT_W-1:0]   last_c;
    logic               nonempty;
    logic               is_op;
    logic               is_find;
    logic               out_free;
    logic               load_out;
    logic               run_done;
    logic [BIT_W-1:0]   lo_b;
    logic [BIT_W-1:0]   hi_b;
    logic               last_word;
    t_word              mask;
    t_word              rdata;
    t_mem_req           mem_req;
    t_scan_ctx          ctx_in;
    t_scan_res          scan_res;

    assign accept   = i_in_valid && !o_in_stall;
    assign out_free = !r_o_valid || !i_out_stall;
    assign is_find  = (r_cmd == CMD_FIND);
    assign load_out = (r_state == S_DONE) && out_free;
    assign run_done = r_dv && (last_word || (is_find && scan_res.found));

    // clip the range or scan to the map
    always_comb begin
        range_end = (CNT_W+1)'(i_start_idx) + (CNT_W+1)'(i_bit_count);
        cand_end  = (i_cmd == CMD_FIND) ? (CNT_W+1)'(i_scan_end) : range_end;
        end_c     = (cand_end > (CNT_W+1)'(MAP_BITS)) ? CNT_W'(MAP_BITS)
                                                      : cand_end[CNT_W-1:0];
        last_c    = end_c - CNT_W'(1);
        nonempty  = end_c > CNT_W'(i_start_idx);
        is_op     = (i_cmd == CMD_SET) || (i_cmd == CMD_CLR) || (i_cmd == CMD_FIND);
    end

    always_comb begin
        last_word = (r_proc_w == r_hi_w);
        lo_b      = (r_proc_w == r_lo_w) ? r_lo_b : '0;
        hi_b      = last_word ? r_hi_b : BIT_W'(WORD_BITS - 1);
        mask      = ({WORD_BITS{1'b1}} << lo_b)
                    & ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - hi_b));
    end

    always_comb begin
        mem_req.rd_en   = (r_state == S_RUN) && r_rd_more;
        mem_req.rd_addr = r_rd_w;
        mem_req.wr_en   = (r_state == S_RUN) && r_dv && !is_find;
        mem_req.wr_addr = r_proc_w;
        mem_req.wr_data = (r_cmd == CMD_SET) ? (rdata | mask) : (rdata & ~mask);
    end

    bra_map_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rdata (rdata)
    );

    assign ctx_in = r_ctx;

    bra_word_scan u_scan (
        .i_data  (rdata),
        .i_mask  (mask),
        .i_lo    (lo_b),
        .i_hi    (hi_b),
        .i_widx  (r_proc_w),
        .i_ctx   (ctx_in),
        .o_res   (scan_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rd_more <= 1'b0;
            r_dv      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (load_out) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && !i_out_stall) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cmd      <= i_cmd;
                        r_lo_w     <= i_start_idx[IDX_W-1 -: WADDR_W];
                        r_hi_w     <= last_c[IDX_W-1 -: WADDR_W];
                        r_lo_b     <= i_start_idx[BIT_W-1:0];
                        r_hi_b     <= last_c[BIT_W-1:0];
                        r_rd_w     <= i_start_idx[IDX_W-1 -: WADDR_W];
                        r_ctx.base  <= i_base_offset;
                        r_ctx.cnt   <= i_carry_count_in;
                        r_ctx.first <= i_carry_first_in;
                        r_ctx.want  <= i_run_length;
                        r_res.found <= 1'b0;
                        r_res.pos   <= '0;
                        if (i_cmd == CMD_FIND) begin
                            r_res.cnt   <= i_carry_count_in;
                            r_res.first <= i_carry_first_in;
                        end else begin
                            r_res.cnt   <= '0;
                            r_res.first <= '0;
                        end
                        r_dv <= 1'b0;
                        if (is_op && nonempty) begin
                            r_rd_more <= 1'b1;
                            r_state   <= S_RUN;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_RUN: begin
                    r_proc_w <= r_rd_w;
                    if (run_done) begin
                        r_rd_more <= 1'b0;
                        r_dv      <= 1'b0;
                        r_state   <= S_DONE;
                    end else begin
                        if (mem_req.rd_en) begin
                            r_rd_w    <= r_rd_w + WADDR_W'(1);
                            r_rd_more <= (r_rd_w != r_hi_w);
                        end
                        r_dv <= mem_req.rd_en;
                    end
                    if (r_dv && is_find) begin
                        if (scan_res.found) begin
                            r_res.found <= 1'b1;
                            r_res.pos   <= scan_res.pos;
                            r_res.cnt   <= '0;
                            r_res.first <= '0;
                        end else begin
                            r_ctx.cnt   <= scan_res.cnt;
                            r_ctx.first <= scan_res.first;
                            if (last_word) begin
                                r_res.cnt   <= scan_res.cnt;
                                r_res.first <= scan_res.first;
                            end
                        end
                    end
                end
                S_DONE: begin
                    if (load_out) begin
                        r_o_res <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_out_valid       = r_o_valid;
    assign o_found           = r_o_res.found;
    assign o_found_position  = r_o_res.pos;
    assign o_carry_count_out = r_o_res.cnt;
    assign o_carry_first_out = r_o_res.first;

    a_found_clears_carry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_found) |-> (o_carry_count_out == '0 && o_carry_first_out == '0))
        else $error("found result with non-zero carry");

    a_miss_no_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> (o_found_position == '0))
        else $error("miss result with non-zero position");

    a_write_only_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_req.wr_en |-> (r_state == S_RUN && !is_find))
        else $error("map write outside a set or clear");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_o_valid && i_out_stall) |=> (r_state == S_DONE))
        else $error("result left while output register full");

endmodule

// ===== hdl/bra_map_mem.sv =====
module bra_map_mem import bra_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mem_req i_req,
    output t_word    o_rdata
);

    t_word                r_mem [MAP_WORDS];
    logic [MAP_WORDS-1:0] r_vld;
    t_word                r_rdata;
    logic                 r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rdata <= r_mem[i_req.rd_addr];
        end
    end

    // words never written read as all free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_vld[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_vld <= r_vld[i_req.rd_addr];
            end
        end
    end

    assign o_rdata = r_rd_vld ? r_rdata : '0;

endmodule

// ===== hdl/bra_word_scan.sv =====
module bra_word_scan import bra_pkg::*; (
    input  t_word              i_data,
    input  t_word              i_mask,
    input  logic [BIT_W-1:0]   i_lo,
    input  logic [BIT_W-1:0]   i_hi,
    input  logic [WADDR_W-1:0] i_widx,
    input  t_scan_ctx          i_ctx,
    output t_scan_res          o_res
);

    function automatic logic [CNT_W-1:0] sat_cnt(input logic [CNT_W:0] v);
        sat_cnt = (v > (CNT_W+1)'(COUNT_MAX)) ? COUNT_MAX : v[CNT_W-1:0];
    endfunction

    t_word              used;
    t_word              free;
    t_word              starts;
    logic [WORD_BITS:0] le_w;
    logic [WORD_BITS:0] lp_w;
    logic [BIT_W:0]     span;
    logic [BIT_W:0]     dist_hi;
    logic [CNT_W-1:0]   sat_a;
    logic [BIT_W-1:0]   p;
    logic               case_a;
    logic               case_b;
    logic               hit;
    logic               hit_a;
    logic [BIT_W-1:0]   hit_j;
    logic               any_u;
    logic [BIT_W-1:0]   last_u;
    logic               any_s;
    logic [BIT_W-1:0]   s_j;
    logic [BIT_W-1:0]   run_b;
    logic [IDX_W-1:0]   pos_idx;
    logic [IDX_W-1:0]   first_idx;

    always_comb begin
        used   = i_data & i_mask;
        free   = ~i_data & i_mask;
        hit    = 1'b0;
        hit_a  = 1'b0;
        hit_j  = '0;
        le_w   = '0;
        lp_w   = '0;
        span   = '0;
        sat_a  = '0;
        p      = '0;
        case_a = 1'b0;
        case_b = 1'b0;
        // lowest matching bit wins
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            le_w   = ((WORD_BITS+1)'(1) << (j + 1)) - (WORD_BITS+1)'(1);
            span   = (BIT_W+1)'(j) - {1'b0, i_lo} + (BIT_W+1)'(1);
            sat_a  = sat_cnt({1'b0, i_ctx.cnt} + (CNT_W+1)'(span));
            case_a = ((used & le_w[WORD_BITS-1:0]) == '0) && (sat_a == i_ctx.want);
            case_b = 1'b0;
            p      = '0;
            lp_w   = '0;
            if (i_ctx.want != '0 && i_ctx.want <= CNT_W'(j)) begin
                p      = BIT_W'(j) - i_ctx.want[BIT_W-1:0];
                lp_w   = ((WORD_BITS+1)'(1) << ({1'b0, p} + (BIT_W+1)'(1)))
                         - (WORD_BITS+1)'(1);
                case_b = used[p]
                         && ((used & le_w[WORD_BITS-1:0] & ~lp_w[WORD_BITS-1:0]) == '0);
            end
            if (free[j] && (case_a || case_b)) begin
                hit   = 1'b1;
                hit_a = case_a;
                hit_j = BIT_W'(j);
            end
        end
    end

    always_comb begin
        starts = free & ((used << 1)
                 | ((i_ctx.cnt == '0) ? (t_word'(1) << i_lo) : '0));
        any_u  = 1'b0;
        last_u = '0;
        any_s  = 1'b0;
        s_j    = '0;
        for (int j = 0; j < WORD_BITS; j++) begin
            if (used[j]) begin
                any_u  = 1'b1;
                last_u = BIT_W'(j);
            end
            if (starts[j]) begin
                any_s = 1'b1;
                s_j   = BIT_W'(j);
            end
        end
    end

    always_comb begin
        run_b     = hit_a ? i_lo : (hit_j - i_ctx.want[BIT_W-1:0] + BIT_W'(1));
        pos_idx   = {i_widx, run_b};
        first_idx = {i_widx, s_j};
        dist_hi   = {1'b0, i_hi} - {1'b0, i_lo} + (BIT_W+1)'(1);

        o_res.found = hit;
        if (hit_a && i_ctx.cnt != '0) begin
            o_res.pos = i_ctx.first;
        end else begin
            o_res.pos = i_ctx.base + POS_W'(pos_idx);
        end
        o_res.cnt   = any_u ? CNT_W'(i_hi - last_u)
                            : sat_cnt({1'b0, i_ctx.cnt} + (CNT_W+1)'(dist_hi));
        o_res.first = any_s ? (i_ctx.base + POS_W'(first_idx)) : i_ctx.first;
    end

endmodule
